// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest unit.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int WORD_W    = 32;
    localparam int BUF_WORDS = 16;
    localparam int BUF_AW    = $clog2(BUF_WORDS);

    localparam logic [31:0] MD5_INIT_A = 32'h67452301;
    localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
    localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
    localparam logic [31:0] MD5_INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    localparam logic [BUF_AW-1:0] LEN_LO_WORD = BUF_AW'(14);
    localparam logic [BUF_AW-1:0] LEN_HI_WORD = BUF_AW'(15);
    localparam logic [BUF_AW-1:0] LAST_WORD   = BUF_AW'(15);
    localparam logic [5:0]        LAST_BYTE   = 6'h3f;

    // [0] = A ... [3] = D
    typedef logic [3:0][WORD_W-1:0] t_words;

    localparam t_words MD5_INIT = {MD5_INIT_D, MD5_INIT_C, MD5_INIT_B, MD5_INIT_A};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLK,
        ST_PAD,
        ST_PADC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic   done;
        t_words words;
    } t_cmp_out;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [BUF_AW-1:0] md5_msg_idx(input logic [5:0] rnd);
        logic [3:0] rl;
        logic [3:0] g;
        rl = rnd[3:0];
        unique case (rnd[5:4])
            2'd0:    g = rl;
            2'd1:    g = 4'(4'd5 * rl + 4'd1);
            2'd2:    g = 4'(4'd3 * rl + 4'd5);
            default: g = 4'(4'd7 * rl);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [1:0] grp,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
        logic [31:0] f;
        unique case (grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/md5_message_digest_unit.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// MD5 hasher taking one message byte per transfer, emitting four digest words.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata is a message byte, s_axis_tuser marks that the
// byte is present, s_axis_tlast ends the message (a transfer with tuser low
// and tlast high ends it without a byte, e.g. the empty message).
// Output stream: four transfers per message, m_axis_tdata is chaining word
// A, B, C, D in turn (low byte = earliest digest byte), m_axis_tuser the word
// index, m_axis_tlast high on word D.
// Timing: a byte that does not close a 64-byte block is stored and the unit
// stays ready. A byte that closes a block starts a compression (64 rounds on
// the one round unit, plus start and finish). At message end the padding
// words are written one per cycle (up to 16), then one compression, or two
// when the byte count mod 64 is 56 or more (second pad pass of 16 words),
// then the digest is offered. s_axis_tready is low throughout.
// While the receiver stalls, the current digest word holds; input stays
// blocked until word D is taken, then the unit returns to its reset state.
// Reset: chaining words take the MD5 initial values, the bit count clears.
// ----------------------------------------------------------------------------
module md5_message_digest_unit
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    t_state            r_state, n_state;
    logic [63:0]       r_cnt, n_cnt;
    t_words            r_chain, n_chain;
    logic              r_end, n_end;
    logic              r_first, n_first;
    logic              r_tail, n_tail;
    logic [BUF_AW-1:0] r_widx, n_widx;
    logic [1:0]        r_oidx, n_oidx;
    logic [31:0]       r_word;

    logic              in_acc;
    logic              out_acc;
    logic [5:0]        pos;
    logic [1:0]        lane;
    logic              two_blk;
    logic              len_sel;
    logic [31:0]       lane_mask;
    logic [31:0]       pad_first;

    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [BUF_AW-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic              cmp_start;
    t_cmp_out          cmp_res;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign pos     = r_cnt[8:3];
    assign lane    = r_cnt[4:3];
    assign two_blk = (r_cnt[8:6] == 3'b111);
    assign len_sel = r_tail || !two_blk;

    always_comb begin
        unique case (lane)
            2'd0:    lane_mask = 32'h0000_0000;
            2'd1:    lane_mask = 32'h0000_00ff;
            2'd2:    lane_mask = 32'h0000_ffff;
            default: lane_mask = 32'h00ff_ffff;
        endcase
    end

    assign pad_first = (r_word & lane_mask) | ({24'd0, PAD_BYTE} << {lane, 3'b000});

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_chain   = r_chain;
        n_end     = r_end;
        n_first   = r_first;
        n_tail    = r_tail;
        n_widx    = r_widx;
        n_oidx    = r_oidx;
        ram_we    = 1'b0;
        ram_waddr = pos[5:2];
        ram_wdata = {s_axis_tdata, r_word[23:0]};
        cmp_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        n_cnt  = r_cnt + 64'd8;
                        ram_we = (lane == 2'd3);
                    end
                    if (s_axis_tuser && pos == LAST_BYTE) begin
                        cmp_start = 1'b1;
                        n_end     = s_axis_tlast;
                        n_state   = ST_BLK;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PAD;
                        n_widx  = n_cnt[8:5];
                        n_first = 1'b1;
                        n_tail  = 1'b0;
                    end
                end
            end
            ST_BLK: begin
                if (cmp_res.done) begin
                    for (int i = 0; i < 4; i++) begin
                        n_chain[i] = r_chain[i] + cmp_res.words[i];
                    end
                    if (r_end) begin
                        n_state = ST_PAD;
                        n_widx  = '0;
                        n_first = 1'b1;
                        n_tail  = 1'b0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                ram_we    = 1'b1;
                ram_waddr = r_widx;
                if (r_first) begin
                    ram_wdata = pad_first;
                end else if (len_sel && r_widx == LEN_LO_WORD) begin
                    ram_wdata = r_cnt[31:0];
                end else if (len_sel && r_widx == LEN_HI_WORD) begin
                    ram_wdata = r_cnt[63:32];
                end else begin
                    ram_wdata = '0;
                end
                n_first = 1'b0;
                n_widx  = BUF_AW'(r_widx + 1'b1);
                if (r_widx == LAST_WORD) begin
                    cmp_start = 1'b1;
                    n_state   = ST_PADC;
                end
            end
            ST_PADC: begin
                if (cmp_res.done) begin
                    for (int i = 0; i < 4; i++) begin
                        n_chain[i] = r_chain[i] + cmp_res.words[i];
                    end
                    if (!r_tail && two_blk) begin
                        n_tail  = 1'b1;
                        n_widx  = '0;
                        n_state = ST_PAD;
                    end else begin
                        n_oidx  = '0;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_oidx = 2'(r_oidx + 2'd1);
                    if (r_oidx == 2'd3) begin
                        n_chain = MD5_INIT;
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_chain <= MD5_INIT;
            r_end   <= 1'b0;
            r_first <= 1'b0;
            r_tail  <= 1'b0;
            r_widx  <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chain <= n_chain;
            r_end   <= n_end;
            r_first <= n_first;
            r_tail  <= n_tail;
            r_widx  <= n_widx;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tuser) begin
            r_word[{lane, 3'b000} +: 8] <= s_axis_tdata;
        end
    end

    md5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUF_WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    md5_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmp_start),
        .i_chain (r_chain),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata),
        .o_res   (cmp_res)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_chain[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 2'd3);

endmodule

// ===== rtl/md5_ram.sv =====
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/md5_cmp.sv =====
// ----------------------------------------------------------------------------
// md5_cmp
// MD5 compression engine: one shared round datapath; each round has a read phase and a sum phase.
// ----------------------------------------------------------------------------
module md5_cmp
    import md5_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_words            i_chain,
    output logic [BUF_AW-1:0] o_raddr,
    input  logic [WORD_W-1:0] i_rdata,
    output t_cmp_out          o_res
);

    logic        r_busy;
    logic        r_ph;
    logic        r_vld;
    logic        r_done;
    logic [6:0]  r_rnd;
    t_words      r_st;
    logic [31:0] r_sum;
    logic [4:0]  r_sh;

    logic [31:0] f_val;
    logic [63:0] rot_wide;
    logic [31:0] b_new;

    assign f_val    = md5_f(r_rnd[5:4], r_st[1], r_st[2], r_st[3]);
    assign rot_wide = {r_sum, r_sum} << r_sh;
    assign b_new    = r_st[1] + rot_wide[63:32];
    assign o_raddr  = md5_msg_idx(r_rnd[5:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_vld  <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
                r_vld  <= 1'b0;
                r_rnd  <= '0;
                r_st   <= i_chain;
            end else if (r_busy) begin
                if (!r_ph) begin
                    // retire the previous round, message word read is in flight
                    if (r_vld) begin
                        r_st[0] <= r_st[3];
                        r_st[1] <= b_new;
                        r_st[2] <= r_st[1];
                        r_st[3] <= r_st[2];
                    end
                    if (r_rnd[6]) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_ph <= 1'b1;
                    end
                end else begin
                    r_sum <= r_st[0] + f_val + K_TAB[r_rnd[5:0]] + i_rdata;
                    r_sh  <= ROT_TAB[{r_rnd[5:4], r_rnd[1:0]}];
                    r_rnd <= 7'(r_rnd + 7'd1);
                    r_vld <= 1'b1;
                    r_ph  <= 1'b0;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.words = r_st;

endmodule

// ===== rtl/md5_sva.sv =====
// ----------------------------------------------------------------------------
// md5_sva
// Port-level checks of the MD5 digest unit, bound to the top level.
// ----------------------------------------------------------------------------
module md5_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("digest transfer changed while stalled");

    a_last_is_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
        else $error("tlast does not match word D");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while digest pending");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser == 2'($past(m_axis_tuser) + 2'd1))
        else $error("digest words out of order");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
            s_axis_tready && !m_axis_tvalid)
        else $error("unit not ready after digest");

endmodule

bind md5_message_digest_unit md5_sva u_md5_sva (.*);

// ===== test/md5_message_digest_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_message_digest_unit_test
// Self-checking bench for the byte-stream MD5 digest unit.
// ----------------------------------------------------------------------------
// Messages go in one byte per transfer, with random gaps and filler
// transfers. A behavioral MD5 model builds the four expected digest words of
// every message, and they are compared with the output stream under random
// receiver stalls. The run covers empty messages, bare end markers, ignored
// bytes, lengths on the block and padding boundaries and random messages.
// ----------------------------------------------------------------------------
module md5_message_digest_unit_test;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] byte_present
    logic        s_axis_tlast;   // message_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [1:0]  m_axis_tuser;   // [1:0] word_index
    logic        m_axis_tlast;   // last_word

    md5_message_digest_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_digest_word digest_q[$];
    t_digest_word want_word;

    logic [31:0] sine_tab[64];
    int          shift_tab[16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                   4, 11, 16, 23, 6, 10, 15, 21};
    logic [31:0] hash_state[4];
    logic [7:0]  block_bytes[64];
    logic [63:0] length_bits;

    int  err_count;
    int  msg_count;
    int  byte_count;
    int  filler_count;
    int  word_count;
    int  stim_items;
    bit  tx_calm;
    int  rx_hold;
    logic rx_level;
    int  rx_pick;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TIMEOUT with %0d digest words outstanding", digest_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------- behavioral MD5 ----------------

    function automatic void init_sine_tab();
        real v;
        for (int i = 0; i < 64; i++) begin
            v = $sin(i + 1);
            if (v < 0.0)
                v = -v;
            sine_tab[i] = 32'(longint'($floor(v * 4294967296.0)));
        end
    endfunction

    function automatic void reset_hash();
        hash_state[0] = 32'h67452301;
        hash_state[1] = 32'hefcdab89;
        hash_state[2] = 32'h98badcfe;
        hash_state[3] = 32'h10325476;
        length_bits   = '0;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] m[16];
        logic [31:0] a, b, c, d, f, t;
        int g;
        for (int k = 0; k < 16; k++)
            m[k] = {block_bytes[4*k+3], block_bytes[4*k+2],
                    block_bytes[4*k+1], block_bytes[4*k]};
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                f = (b & c) | (~b & d);
                g = r;
            end else if (r < 32) begin
                f = (b & d) | (c & ~d);
                g = (5 * r + 1) % 16;
            end else if (r < 48) begin
                f = b ^ c ^ d;
                g = (3 * r + 5) % 16;
            end else begin
                f = c ^ (b | ~d);
                g = (7 * r) % 16;
            end
            t = d;
            d = c;
            c = b;
            b = b + rotl(a + f + sine_tab[r] + m[g], shift_tab[(r / 16) * 4 + r % 4]);
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
    endfunction

    // byte first, then padding and digest on message end
    function automatic void predict_digest(input logic [7:0] data, input logic present,
                                           input logic last);
        int pos;
        logic [63:0] len_snap;
        t_digest_word rec;
        if (present) begin
            pos = int'(length_bits[8:3]);
            block_bytes[pos] = data;
            length_bits += 64'd8;
            if (pos == 63)
                compress_block();
        end
        if (last) begin
            pos = int'(length_bits[8:3]);
            len_snap = length_bits;
            block_bytes[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++)
                block_bytes[56 + k] = len_snap[8*k +: 8];
            compress_block();
            for (int k = 0; k < 4; k++) begin
                rec.word  = hash_state[k];
                rec.index = 2'(k);
                rec.last  = (k == 3);
                digest_q.push_back(rec);
            end
            reset_hash();
        end
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("digest word with none expected", m_axis_tdata, '0);
            end else begin
                want_word = digest_q.pop_front();
                if (m_axis_tdata !== want_word.word)
                    report_mismatch("digest_word", m_axis_tdata, want_word.word);
                if (m_axis_tuser !== want_word.index)
                    report_mismatch("word_index", 32'(m_axis_tuser), 32'(want_word.index));
                if (m_axis_tlast !== want_word.last)
                    report_mismatch("last_word", 32'(m_axis_tlast), 32'(want_word.last));
                word_count++;
            end
        end
    end

    // ---------------- receiver stalls ----------------

    initial begin
        m_axis_tready = 1'b0;
        rx_hold  = 0;
        rx_level = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold == 0) begin
                rx_pick = $urandom_range(0, 99);
                if (rx_pick < 10) begin
                    rx_level = 1'b1;
                    rx_hold  = $urandom_range(100, 300);
                end else if (rx_pick < 55) begin
                    rx_level = 1'b1;
                    rx_hold  = $urandom_range(1, 6);
                end else if (rx_pick < 85) begin
                    rx_level = 1'b0;
                    rx_hold  = $urandom_range(1, 2);
                end else if (rx_pick < 97) begin
                    rx_level = 1'b0;
                    rx_hold  = $urandom_range(3, 10);
                end else begin
                    rx_level = 1'b0;
                    rx_hold  = $urandom_range(20, 80);
                end
            end
            rx_hold--;
            m_axis_tready <= rx_level;
        end
    end

    // ---------------- sender ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [7:0] data, input logic present, input logic last);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            s_axis_tuser  <= 1'($urandom_range(0, 1));
            s_axis_tlast  <= 1'($urandom_range(0, 1));
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predict_digest(data, present, last);
        if (present)
            byte_count++;
        else if (!last)
            filler_count++;
        if (last)
            msg_count++;
    endtask

    task automatic tx_release();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // drop tvalid first so the accepted transfer is not taken again
    task automatic wait_digests();
        tx_release();
        while (digest_q.size() != 0)
            @(posedge i_clk);
    endtask

    // random content; the end either rides on the last byte or comes bare
    task automatic send_message(input int len, input logic end_on_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 8)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
            stim_items++;
        end
        if (len == 0 || !end_on_byte) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            stim_items++;
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_end_markers();
        tx_calm = 1'b0;
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        wait_digests();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hc3, 1'b0, 1'b1);
    endtask

    task automatic test_block_boundaries();
        int lens[5] = '{55, 56, 63, 64, 120};
        foreach (lens[i]) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            send_message(lens[i], 1'($urandom_range(0, 1)));
        end
        tx_calm = 1'b0;
        wait_digests();
    endtask

    task automatic test_random_messages();
        int r;
        int len;
        while (stim_items < 440) begin
            r = $urandom_range(0, 99);
            if (r < 75)
                len = $urandom_range(0, 24);
            else if (r < 93)
                len = $urandom_range(25, 70);
            else
                len = $urandom_range(54, 66);
            tx_calm = ($urandom_range(0, 3) == 0);
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
                wait_digests();
        end
        tx_calm = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        err_count     = 0;
        msg_count     = 0;
        byte_count    = 0;
        filler_count  = 0;
        word_count    = 0;
        stim_items    = 0;
        tx_calm       = 1'b0;
        init_sine_tab();
        reset_hash();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_end_markers();
        wait_digests();
        test_block_boundaries();
        test_random_messages();
        tx_release();
        wait_digests();
        repeat (500) @(posedge i_clk);

        $display("Hashed %0d messages, %0d bytes, %0d filler transfers; %0d digest words checked.",
                 msg_count, byte_count, filler_count, word_count);
        $display("Included empty messages, bare end markers and lengths around 56/64/120 bytes.");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
